### src/psf_pkg.sv
`default_nettype none
package psf_pkg;
   localparam int MaxWidth = 63;
   localparam int MaxPrecision = 52;

   typedef enum logic [1:0] {
      PH_LITERAL = 2'd0,
      PH_CONV    = 2'd1,
      PH_WIDTH   = 2'd2,
      PH_PREC    = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_DIGITS = 3'd1,
      ST_PAD    = 3'd2,
      ST_SIGN   = 3'd3,
      ST_ZEROS  = 3'd4,
      ST_BODY   = 3'd5,
      ST_NULL   = 3'd6
   } state_type;

   // one step of the shared digit unit
   typedef struct packed {
      logic        start;
      logic        hex;
      logic [31:0] value;
   } dig_cmd_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [3:0]  len;
   } dig_sts_type;

   function automatic logic [7:0] null_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h28;
         3'd1:    c = 8'h6e;
         3'd2:    c = 8'h75;
         3'd3:    c = 8'h6c;
         3'd4:    c = 8'h6c;
         default: c = 8'h29;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      return (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h57 + {4'd0, d});
   endfunction
endpackage
`default_nettype wire

### src/psf_digit_unit.sv
`default_nettype none
// Extracts digits least significant first, one per cycle, into a small
// digit store; the emitter reads them back most significant first.
module psf_digit_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire psf_pkg::dig_cmd_type cmd,
   input  wire logic [3:0]           rd_idx,
   output logic [3:0]                rd_digit,
   output psf_pkg::dig_sts_type      sts
);
   logic [31:0] val_ff, val_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic        hex_ff, hex_in;
   logic [3:0]  len_ff, len_in;
   logic [3:0]  digs_ff [10];
   logic [31:0] quot;
   logic [3:0]  rem;
   logic [63:0] prod;

   // divide by ten through a reciprocal multiply, or by sixteen with a shift in hex mode
   always_comb begin
      prod = {32'd0, val_ff} * 64'hCCCCCCCD;
      quot = {3'd0, prod[63:35]};
      rem  = 4'(val_ff - quot * 32'd10);
      if (hex_ff) begin
         quot = {4'd0, val_ff[31:4]};
         rem  = val_ff[3:0];
      end
   end

   always_comb begin
      val_in  = val_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      hex_in  = hex_ff;
      len_in  = len_ff;
      if (cmd.start) begin
         val_in  = cmd.value;
         hex_in  = cmd.hex;
         busy_in = 1'b1;
         len_in  = '0;
      end else if (busy_ff) begin
         val_in = quot;
         len_in = len_ff + 4'd1;
         if (quot == 32'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         len_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         len_ff  <= len_in;
      end
      val_ff <= val_in;
      hex_ff <= hex_in;
      if (busy_ff && !cmd.start) digs_ff[len_ff] <= rem;
   end

   assign rd_digit = digs_ff[rd_idx];
   assign sts = '{busy: busy_ff, done: done_ff, len: len_ff};
endmodule
`default_nettype wire

### src/printf_subset_formatter.sv
`default_nettype none
// printf_subset_formatter: streams format bytes in, characters out.
// Input beats (req_) carry one format byte or one string byte each; output
// beats (rsp_) carry one character with the running count and tlast on the
// final character caused by an input beat. Beats that cause no character
// produce no output beat.
// A literal or string byte gives its character the cycle after it is
// accepted. A d or x conversion first runs the digit unit, one digit per
// cycle (up to ten decimal or eight hex digits), then walks padding, sign,
// zeros and digits, one character a cycle while rsp_tready stays high. An s
// conversion walks the padding and then, for a null argument, the null
// text. req_tready is high only while the sequencer is in idle and the
// output register is empty or being taken, so no new beat is taken until
// a conversion has finished. The digit unit (one reciprocal multiply per
// cycle) and the one-character output register set the pace.
// Reset clears the parser, the pending string count and the running count.
// When rsp_tready is low the current character holds and the sequencer
// waits; nothing is dropped.
module printf_subset_formatter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // ch[7:0], arg_value[39:8], arg_null[40], zero
   input  wire logic        req_tuser,  // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // out_char[7:0], char_count[39:8]
   output logic             rsp_tlast   // last_in_run
);
   psf_pkg::phase_type phase_ff, phase_in;
   psf_pkg::state_type state_ff, state_in;
   logic [5:0]  width_ff, width_in, prec_ff, prec_in;
   logic        point_ff, point_in;
   logic [31:0] left_ff, left_in, total_ff, total_in;
   logic [5:0]  pad_ff, pad_in, zeros_ff, zeros_in;
   logic [3:0]  idx_ff, idx_in;
   logic        neg_ff, neg_in, sdig_ff, sdig_in;
   logic        zero_ff, zero_in;
   logic        ov_ff, ov_in, olast_ff, olast_in;
   logic [7:0]  och_ff, och_in;
   logic [2:0]  nlen_ff, nlen_in;

   psf_pkg::dig_cmd_type cmd;
   psf_pkg::dig_sts_type sts;
   logic [3:0] rd_digit;

   logic        take, free;
   logic [7:0]  ch;
   logic [31:0] arg;
   logic        isnull;
   logic [3:0]  dv;
   logic [6:0]  wnum;
   logic [9:0]  pnum;
   logic [31:0] slen;
   logic [3:0]  len;
   logic [6:0]  body;

   assign ch     = req_tdata[7:0];
   assign arg    = req_tdata[39:8];
   assign isnull = req_tdata[40];
   assign free   = !ov_ff || rsp_tready;
   assign req_tready = (state_ff == psf_pkg::ST_IDLE) && free;
   assign take   = req_tvalid && req_tready;
   assign dv     = ch[3:0];

   psf_digit_unit u_dig (
      .clock(clock), .reset(reset), .cmd(cmd),
      .rd_idx(idx_ff - 4'd1), .rd_digit(rd_digit), .sts(sts)
   );

   // width/precision accumulation and the number of digits printed
   always_comb begin
      wnum = (phase_ff == psf_pkg::PH_WIDTH) ? 7'({1'b0, width_ff} * 7'd10) : 7'd0;
      wnum = 7'(wnum + {3'd0, dv});
      pnum = {4'd0, prec_ff} * 10'd10 + {6'd0, dv};
      slen = isnull ? 32'd6 : arg;
      if (point_ff && slen > {26'd0, prec_ff}) slen = {26'd0, prec_ff};
      // zero value with an explicit precision of 0 prints no digits
      len  = (sdig_ff && zero_ff && point_ff && prec_ff == 6'd0) ? 4'd0 : sts.len;
      body = 7'({2'd0, len} + {6'd0, neg_ff});
      if (prec_ff > {2'd0, len}) body = 7'({1'b0, prec_ff} + {6'd0, neg_ff});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         psf_pkg::ST_IDLE:
            if (take && !req_tuser && ch != 8'd0 && phase_ff != psf_pkg::PH_LITERAL) begin
               if (ch == 8'h64 || ch == 8'h78) state_in = psf_pkg::ST_DIGITS;
               else if (ch == 8'h73) state_in = psf_pkg::ST_PAD;
            end
         psf_pkg::ST_DIGITS: if (sts.done) state_in = psf_pkg::ST_PAD;
         psf_pkg::ST_PAD:
            if (free && pad_ff == 6'd0)
               state_in = sdig_ff ? psf_pkg::ST_SIGN : psf_pkg::ST_NULL;
         psf_pkg::ST_SIGN: if (free) state_in = psf_pkg::ST_ZEROS;
         psf_pkg::ST_ZEROS: if (free && zeros_ff == 6'd0) state_in = psf_pkg::ST_BODY;
         psf_pkg::ST_BODY: if (free && idx_ff == 4'd0) state_in = psf_pkg::ST_IDLE;
         psf_pkg::ST_NULL: if (free && nlen_ff == 3'd0) state_in = psf_pkg::ST_IDLE;
         default: state_in = psf_pkg::ST_IDLE;
      endcase
   end

   // datapath and character emission
   always_comb begin
      phase_in = phase_ff; width_in = width_ff; prec_in = prec_ff;
      point_in = point_ff; left_in = left_ff; total_in = total_ff;
      pad_in = pad_ff; zeros_in = zeros_ff; idx_in = idx_ff;
      neg_in = neg_ff; sdig_in = sdig_ff; nlen_in = nlen_ff; zero_in = zero_ff;
      ov_in = ov_ff && !rsp_tready; och_in = och_ff; olast_in = olast_ff;
      cmd = '{start: 1'b0, hex: 1'b0, value: 32'd0};
      case (state_ff)
         psf_pkg::ST_IDLE: if (take) begin
            if (req_tuser) begin
               if (left_ff != 32'd0) begin
                  left_in = left_ff - 32'd1;
                  ov_in = 1'b1; och_in = ch; olast_in = 1'b1;
                  total_in = total_ff + 32'd1;
               end
            end else if (ch == 8'd0) begin
               phase_in = psf_pkg::PH_LITERAL;
               width_in = '0; prec_in = '0; point_in = 1'b0;
            end else if (phase_ff == psf_pkg::PH_LITERAL) begin
               if (ch == 8'h25) begin
                  phase_in = psf_pkg::PH_CONV;
                  width_in = '0; prec_in = '0; point_in = 1'b0;
               end else begin
                  ov_in = 1'b1; och_in = ch; olast_in = 1'b1;
                  total_in = total_ff + 32'd1;
               end
            end else if (ch >= 8'h30 && ch <= 8'h39) begin
               if (phase_ff == psf_pkg::PH_PREC) begin
                  if (pnum > 10'(psf_pkg::MaxPrecision))
                     prec_in = 6'(psf_pkg::MaxPrecision);
                  else prec_in = pnum[5:0];
               end else begin
                  width_in = (wnum > 7'(psf_pkg::MaxWidth) || (phase_ff ==
                     psf_pkg::PH_WIDTH && width_ff > 6'd9)) ?
                     6'(psf_pkg::MaxWidth) : wnum[5:0];
                  phase_in = psf_pkg::PH_WIDTH;
               end
            end else if (ch == 8'h2e) begin
               point_in = 1'b1; prec_in = '0; phase_in = psf_pkg::PH_PREC;
            end else if (ch == 8'h64 || ch == 8'h78) begin
               neg_in = (ch == 8'h64) && arg[31];
               sdig_in = 1'b1;
               zero_in = (arg == 32'd0);
               cmd = '{start: 1'b1, hex: (ch == 8'h78),
                       value: ((ch == 8'h64) && arg[31]) ? 32'd0 - arg : arg};
               phase_in = psf_pkg::PH_LITERAL;
            end else if (ch == 8'h73) begin
               sdig_in = 1'b0;
               pad_in = ({26'd0, width_ff} > slen) ? 6'(width_ff - slen[5:0]) : 6'd0;
               nlen_in = isnull ? slen[2:0] : 3'd0;
               idx_in = '0;
               left_in = isnull ? 32'd0 : slen;
               phase_in = psf_pkg::PH_LITERAL;
               width_in = '0; prec_in = '0; point_in = 1'b0;
            end else phase_in = psf_pkg::PH_CONV;
         end
         psf_pkg::ST_DIGITS: if (sts.done) begin
            pad_in   = ({1'b0, width_ff} > body) ? 6'(width_ff - body[5:0]) : 6'd0;
            zeros_in = (prec_ff > {2'd0, len}) ? 6'(prec_ff - {2'd0, len}) : 6'd0;
            idx_in   = len;
            width_in = '0; prec_in = '0; point_in = 1'b0;
         end
         psf_pkg::ST_PAD: if (free && pad_ff != 6'd0) begin
            pad_in = pad_ff - 6'd1;
            ov_in = 1'b1; och_in = 8'h20; total_in = total_ff + 32'd1;
            olast_in = (pad_ff == 6'd1) && (sdig_ff ? (!neg_ff && zeros_ff == 6'd0
                        && idx_ff == 4'd0) : nlen_ff == 3'd0);
         end
         psf_pkg::ST_SIGN: if (free && neg_ff) begin
            ov_in = 1'b1; och_in = 8'h2d; total_in = total_ff + 32'd1;
            olast_in = zeros_ff == 6'd0 && idx_ff == 4'd0;
         end
         psf_pkg::ST_ZEROS: if (free && zeros_ff != 6'd0) begin
            zeros_in = zeros_ff - 6'd1;
            ov_in = 1'b1; och_in = 8'h30; total_in = total_ff + 32'd1;
            olast_in = zeros_ff == 6'd1 && idx_ff == 4'd0;
         end
         psf_pkg::ST_BODY: if (free && idx_ff != 4'd0) begin
            idx_in = idx_ff - 4'd1;
            ov_in = 1'b1; och_in = psf_pkg::digit_char(rd_digit);
            total_in = total_ff + 32'd1; olast_in = idx_ff == 4'd1;
         end
         psf_pkg::ST_NULL: if (free && nlen_ff != 3'd0) begin
            nlen_in = nlen_ff - 3'd1;
            ov_in = 1'b1; och_in = psf_pkg::null_char(idx_ff[2:0]);
            idx_in = idx_ff + 4'd1;
            total_in = total_ff + 32'd1; olast_in = nlen_ff == 3'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psf_pkg::ST_IDLE;
         phase_ff <= psf_pkg::PH_LITERAL;
         width_ff <= '0; prec_ff <= '0; point_ff <= 1'b0;
         left_ff  <= '0; total_ff <= '0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in;
         width_ff <= width_in; prec_ff <= prec_in; point_ff <= point_in;
         left_ff  <= left_in;  total_ff <= total_in; ov_ff <= ov_in;
      end
      pad_ff <= pad_in; zeros_ff <= zeros_in; idx_ff <= idx_in;
      neg_ff <= neg_in; sdig_ff <= sdig_in; nlen_ff <= nlen_in;
      zero_ff <= zero_in;
      och_ff <= och_in; olast_ff <= olast_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {total_ff, och_ff};
   assign rsp_tlast  = olast_ff;

   // the running count advances by exactly one per new character
   a_count: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && rsp_tready) ##1 ov_ff |-> (total_ff == $past(total_ff) + 32'd1))
      else $error("count");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != psf_pkg::ST_IDLE) |-> !req_tready) else $error("ready while busy");
   a_digits: assert property (@(posedge clock) disable iff (reset)
      sts.busy |-> (state_ff == psf_pkg::ST_DIGITS)) else $error("digit unit stray");
   a_len: assert property (@(posedge clock) disable iff (reset)
      sts.len <= 4'd10) else $error("digit overflow");
endmodule
`default_nettype wire

### tb/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]  ch;
      logic [31:0] count;
      logic        last;
   } char_beat_type;

   // expected characters and the formatter state that produces them
   class fmt_scoreboard;
      char_beat_type pending_chars[$];
      psf_pkg::phase_type phase;
      int unsigned fwidth, fprec, str_left;
      bit          point;
      logic [31:0] total;
      int unsigned errors;

      function void clear_spec();
         fwidth = 0;
         fprec = 0;
         point = 0;
      endfunction

      function void clear_all();
         phase = psf_pkg::PH_LITERAL;
         clear_spec();
         str_left = 0;
         total = 0;
         errors = 0;
         pending_chars.delete();
      endfunction

      function void push_char(logic [7:0] c);
         char_beat_type b;
         total = total + 1;
         b.ch = c;
         b.count = total;
         b.last = 0;
         pending_chars.push_back(b);
      endfunction

      function void push_number(logic [31:0] mag, bit neg, bit hex);
         logic [7:0] digs[12];
         int unsigned len, zeros, body, pad, d;
         logic [31:0] v;
         len = 0;
         v = mag;
         do begin
            d = hex ? v % 16 : v % 10;
            digs[len] = (d < 10) ? 8'(8'h30 + d) : 8'(8'h61 + d - 10);
            len++;
            v = hex ? v / 16 : v / 10;
         end while (v != 0);
         if (mag == 0 && point && fprec == 0) len = 0;
         zeros = fprec > len ? fprec - len : 0;
         body = len + zeros + (neg ? 1 : 0);
         pad = fwidth > body ? fwidth - body : 0;
         repeat (pad) push_char(" ");
         if (neg) push_char("-");
         repeat (zeros) push_char("0");
         for (int i = len; i > 0; i--) push_char(digs[i-1]);
      endfunction

      // note an accepted input beat
      function void note_input(bit is_str, logic [7:0] c, logic [31:0] arg, bit isnull);
         int unsigned n0, slen, p, w;
         n0 = pending_chars.size();
         if (is_str) begin
            if (str_left != 0) begin
               str_left--;
               push_char(c);
            end
         end else if (c == 8'h00) begin
            phase = psf_pkg::PH_LITERAL;
            clear_spec();
         end else if (phase == psf_pkg::PH_LITERAL) begin
            if (c == "%") begin
               clear_spec();
               phase = psf_pkg::PH_CONV;
            end else push_char(c);
         end else if (c >= "0" && c <= "9") begin
            if (phase == psf_pkg::PH_PREC) begin
               p = fprec * 10 + (c - "0");
               fprec = p > psf_pkg::MaxPrecision ? psf_pkg::MaxPrecision : p;
            end else begin
               w = (phase == psf_pkg::PH_WIDTH ? fwidth * 10 : 0) + (c - "0");
               fwidth = w > psf_pkg::MaxWidth ? psf_pkg::MaxWidth : w;
               phase = psf_pkg::PH_WIDTH;
            end
         end else if (c == ".") begin
            point = 1;
            fprec = 0;
            phase = psf_pkg::PH_PREC;
         end else if (c == "d") begin
            push_number(arg[31] ? 32'd0 - arg : arg, arg[31], 0);
            phase = psf_pkg::PH_LITERAL;
            clear_spec();
         end else if (c == "x") begin
            push_number(arg, 0, 1);
            phase = psf_pkg::PH_LITERAL;
            clear_spec();
         end else if (c == "s") begin
            slen = isnull ? 6 : arg;
            if (point && slen > fprec) slen = fprec;
            if (fwidth > slen) repeat (fwidth - slen) push_char(" ");
            if (isnull) begin
               for (int i = 0; i < slen && i < 6; i++)
                  push_char(psf_pkg::null_char(3'(i)));
               str_left = 0;
            end else str_left = slen;
            phase = psf_pkg::PH_LITERAL;
            clear_spec();
         end else phase = psf_pkg::PH_CONV;
         if (pending_chars.size() > n0)
            pending_chars[pending_chars.size()-1].last = 1;
      endfunction

      // compare one output beat with the oldest expectation
      function void check_output(logic [7:0] c, logic [31:0] cnt, logic last);
         char_beat_type e;
         if (pending_chars.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected char %h count %0d", c, cnt);
            return;
         end
         e = pending_chars.pop_front();
         if (e.ch !== c || e.count !== cnt || e.last !== last) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp ch %h cnt %0d last %b, got ch %h cnt %0d last %b",
                        e.ch, e.count, e.last, c, cnt, last);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   fmt_scoreboard sb = new();
   int unsigned cycles = 0;
   bit          hold_off = 0;

   always #5 clock = ~clock;

   printf_subset_formatter DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 600000) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // receiver: own stall pattern, plus a long hold-off when asked
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_output(rsp_tdata[7:0], rsp_tdata[39:8], rsp_tlast);
      if (hold_off) rsp_tready <= 0;
      else if (cycles[9:8] == 2'd0) rsp_tready <= 1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   int unsigned burst_left = 0;

   // offer one beat, with burst gaps, until accepted
   task automatic send_beat(bit is_str, logic [7:0] c, logic [31:0] arg, bit isnull);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1;
      req_tuser <= is_str;
      req_tdata <= {7'd0, isnull, arg, c};
      do @(posedge clock); while (!req_tready);
      sb.note_input(is_str, c, arg, isnull);
   endtask

   task automatic send_text(string s, logic [31:0] arg, bit isnull);
      for (int i = 0; i < s.len(); i++) send_beat(0, s[i], arg, isnull);
   endtask

   function automatic logic [31:0] rand_arg();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 0;
         3: return $urandom_range(0, 999);
         default: return $urandom;
      endcase
   endfunction

   // random conversion with random flags
   task automatic send_random_spec();
      byte spec;
      logic [31:0] arg;
      send_beat(0, "%", 0, 0);
      if ($urandom_range(0, 1)) send_beat(0, 8'("0" + $urandom_range(0, 9)), 0, 0);
      if ($urandom_range(0, 3) == 0) send_beat(0, 8'("0" + $urandom_range(0, 9)), 0, 0);
      if ($urandom_range(0, 1)) begin
         send_beat(0, ".", 0, 0);
         if ($urandom_range(0, 2)) send_beat(0, 8'("0" + $urandom_range(0, 9)), 0, 0);
      end
      case ($urandom_range(0, 2))
         0: spec = "d";
         1: spec = "x";
         default: spec = "s";
      endcase
      arg = rand_arg();
      if (spec == "s") arg = $urandom_range(0, 5);
      send_beat(0, spec, arg, $urandom_range(0, 3) == 0);
      while (sb.str_left != 0 && $urandom_range(0, 7) != 0)
         send_beat(1, 8'($urandom), $urandom, 1'($urandom));
   endtask

   task automatic wait_drained();
      while (sb.pending_chars.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      sb.clear_all();
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: literals, all specifiers, corner cases
      send_text("A%d", 32'h8000_0000, 0);
      send_text("%.0d", 0, 0);
      send_text("%5.0x", 0, 0);
      send_text("%99.99x", 32'hFFFF_FFFF, 0);
      send_text("%3.4s", 0, 1);
      send_text("%8s", 3, 0);
      send_beat(1, 8'h00, 0, 0);
      send_beat(1, 8'hFF, 32'hFFFF_FFFF, 1);
      send_beat(1, 8'h41, 0, 0);
      send_beat(1, 8'h42, 0, 0);
      send_text("%%q1.2.3", 0, 0);
      send_beat(0, 8'h00, 0, 0);
      send_beat(0, 8'hFF, 0, 0);

      // long receiver hold-off while the sender keeps going
      hold_off = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         repeat (6) send_text("%12d", 32'h7FFF_FFFF, 0);
      join

      // random part: mostly conversions, some noise
      for (int n = 0; n < 40; n++) begin
         case ($urandom_range(0, 9))
            0: send_beat(1'($urandom_range(0, 1)), 8'($urandom), $urandom, 1'($urandom));
            1: send_beat(0, 8'h00, 0, 0);
            2, 3: send_beat(0, 8'("a" + $urandom_range(0, 25)), $urandom, 1'($urandom));
            default: send_random_spec();
         endcase
      end
      req_tvalid <= 0;

      wait_drained();
      if (sb.errors == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
